>>> hw/rtl/x86bpd_pkg.sv
// Shared item types, opcode constants and decode helpers for the x86 predecoder.
package x86bpd_pkg;

  // Input item: one instruction window
  typedef struct packed {
    logic [63:0] instr_address;
    logic [63:0] instr_window;
    logic [3:0]  valid_bytes;
    logic        long_mode;
  } in_item_t;

  // Result item: branch flags, direct target and length
  typedef struct packed {
    logic        is_call;
    logic        is_return;
    logic        is_cond_branch;
    logic [63:0] target_address;
    logic [3:0]  instr_length;
  } out_item_t;

  // Opcodes
  localparam logic [7:0] OpCallRel  = 8'hE8;
  localparam logic [7:0] OpGrp5     = 8'hFF;
  localparam logic [7:0] OpCallFar  = 8'h9A;
  localparam logic [7:0] OpRetNear  = 8'hC3;
  localparam logic [7:0] OpRetNearI = 8'hC2;
  localparam logic [7:0] OpRetFar   = 8'hCB;
  localparam logic [7:0] OpRetFarI  = 8'hCA;
  localparam logic [7:0] OpEscape   = 8'h0F;
  localparam logic [7:0] OpJmpRel   = 8'hE9;
  localparam logic [7:0] OpJmpShort = 8'hEB;
  localparam logic [7:0] OpOpSize   = 8'h66;
  localparam logic [7:0] OpNop      = 8'h90;
  localparam logic [7:0] OpInt3     = 8'hCC;
  localparam logic [2:0] ModRmCall  = 3'd2;

  // Legacy prefix bytes
  function automatic logic is_legacy_prefix(input logic [7:0] b);
    return b == OpOpSize || b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
           b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 ||
           b == 8'h64 || b == 8'h65;
  endfunction

  // REX prefix range 40-4F
  function automatic logic is_rex(input logic [7:0] b);
    return b[7:4] == 4'h4;
  endfunction

  // Length of the opcode part, counted from the opcode byte
  function automatic logic [3:0] opcode_len(input logic [7:0] op, input logic [7:0] op2,
                                            input logic op2_ok, input logic lm);
    logic [3:0] len;
    len = 4'd2;
    if (op == OpNop || op == OpRetNear || op == OpRetFar || op == OpInt3) begin
      len = 4'd1;
    end else if (op == OpRetNearI || op == OpRetFarI) begin
      len = 4'd3;
    end else if (op[7:4] == 4'h5) begin
      len = 4'd1;
    end else if (op[7:3] == 5'b10110) begin
      len = 4'd2;
    end else if (op[7:3] == 5'b10111) begin
      len = lm ? 4'd9 : 4'd5;
    end else if (op == OpCallRel || op == OpJmpRel) begin
      len = 4'd5;
    end else if (op == OpJmpShort) begin
      len = 4'd2;
    end else if (op[7:4] == 4'h7) begin
      len = 4'd2;
    end else if (op == OpEscape && op2_ok) begin
      if (op2[7:4] == 4'h8) begin
        len = 4'd6;
      end else if (op2 == 8'hB6 || op2 == 8'hB7 || op2 == 8'hBE || op2 == 8'hBF) begin
        len = 4'd3;
      end
    end
    return len;
  endfunction

endpackage

>>> hw/rtl/x86bpd_if.sv
// Valid/ready channel interfaces for predecoder input and result items.
interface x86bpd_in_if;
  logic                 valid;
  logic                 ready;
  x86bpd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface x86bpd_out_if;
  logic                  valid;
  logic                  ready;
  x86bpd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/x86_branch_and_length_predecode.sv
// An accepted item passes three register stages before its result appears on out_o.
// Throughput: one item per cycle while out_o is not stalled; the target adder is split over stages 1 and 2.
// Stalls on out_o back up stage by stage; bubbles are filled, nothing is dropped.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; the data registers are not reset.
module x86_branch_and_length_predecode #(
  parameter int WINDOW_BYTES = 8,
  parameter int MAX_PREFIXES = 4
) (
  input logic         clk_i,
  input logic         rst_ni,
  x86bpd_in_if.sink   in_i,
  x86bpd_out_if.source out_o
);
  import x86bpd_pkg::*;

  localparam int          Keep   = MAX_PREFIXES + 2;
  localparam int          Pw     = $clog2(MAX_PREFIXES + 1);
  localparam logic [4:0]  WinLim = 5'(WINDOW_BYTES);

  // Stage handshake
  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, adv3;

  assign adv3   = !v3_q || out_o.ready;
  assign ready2 = !v2_q || adv3;
  assign ready1 = !v1_q || ready2;
  assign in_i.ready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_i.valid;
      if (ready2) v2_q <= v1_q;
      if (adv3)   v3_q <= v2_q;
    end
  end

  // ---------------- Stage 1: classify byte 0, start target add ----------------
  logic [3:0]  n_d;
  logic [7:0]  b0, b1;
  logic        call_d, ret_d, cond_d;
  logic        tgt_en_d;
  logic [3:0]  tgt_base;
  logic [31:0] off_d;
  logic [63:0] addr_base_d;
  logic [MAX_PREFIXES-1:0] leg_d, rex_d;

  always_comb begin
    n_d = ({1'b0, in_i.data.valid_bytes} > WinLim) ? WinLim[3:0] : in_i.data.valid_bytes;
    b0  = in_i.data.instr_window[7:0];
    b1  = in_i.data.instr_window[15:8];

    // Branch flags from byte 0
    call_d = 1'b0;
    ret_d  = 1'b0;
    cond_d = 1'b0;
    if (n_d != 4'd0) begin
      call_d = (b0 == OpCallRel) || (b0 == OpCallFar) ||
               (b0 == OpGrp5 && n_d >= 4'd2 && b1[5:3] == ModRmCall);
      ret_d  = (b0 == OpRetNear) || (b0 == OpRetNearI) ||
               (b0 == OpRetFar) || (b0 == OpRetFarI);
      cond_d = (b0[7:4] == 4'h7) ||
               (b0 == OpEscape && n_d >= 4'd2 && b1[7:4] == 4'h8) ||
               (b0[7:2] == 6'b111000);
    end

    // Pick encoding length and offset for a direct target
    tgt_en_d = 1'b0;
    tgt_base = 4'd0;
    off_d    = '0;
    if (n_d >= 4'd2) begin
      if ((b0 == OpCallRel || b0 == OpJmpRel) && n_d >= 4'd5) begin
        tgt_en_d = 1'b1;
        tgt_base = 4'd5;
        off_d    = in_i.data.instr_window[39:8];
      end else if (b0 == OpJmpShort || b0[7:4] == 4'h7) begin
        tgt_en_d = 1'b1;
        tgt_base = 4'd2;
        off_d    = {{24{b1[7]}}, b1};
      end else if (b0 == OpEscape && n_d >= 4'd6 && b1[7:4] == 4'h8) begin
        tgt_en_d = 1'b1;
        tgt_base = 4'd6;
        off_d    = in_i.data.instr_window[47:16];
      end
    end
    addr_base_d = in_i.data.instr_address + {60'd0, tgt_base};

    // Prefix class of each byte the scan can reach
    for (int i = 0; i < MAX_PREFIXES; i++) begin
      leg_d[i] = is_legacy_prefix(in_i.data.instr_window[8*i +: 8]);
      rex_d[i] = is_rex(in_i.data.instr_window[8*i +: 8]);
    end
  end

  logic [3:0]        n1_q;
  logic              lm1_q, call1_q, ret1_q, cond1_q, tgt_en1_q;
  logic [31:0]       off1_q;
  logic [63:0]       addr_base1_q;
  logic [MAX_PREFIXES-1:0] leg1_q, rex1_q;
  logic [8*Keep-1:0] bytes1_q;

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      n1_q         <= n_d;
      lm1_q        <= in_i.data.long_mode;
      call1_q      <= call_d;
      ret1_q       <= ret_d;
      cond1_q      <= cond_d;
      tgt_en1_q    <= tgt_en_d;
      off1_q       <= off_d;
      addr_base1_q <= addr_base_d;
      leg1_q       <= leg_d;
      rex1_q       <= rex_d;
      bytes1_q     <= in_i.data.instr_window[8*Keep-1:0];
    end
  end

  // ---------------- Stage 2: finish target, scan prefixes ----------------
  logic [63:0]   tgt_d;
  logic [Pw-1:0] p_d;
  logic          scan_done;
  logic [7:0]    op_d, op2_d;
  logic          op2_ok_d;

  always_comb begin
    tgt_d = tgt_en1_q ? addr_base1_q + {{32{off1_q[31]}}, off1_q} : 64'd0;

    // Count prefixes; a REX byte in long mode ends the scan
    p_d       = '0;
    scan_done = 1'b0;
    for (int i = 0; i < MAX_PREFIXES; i++) begin
      if (!scan_done && i < int'(n1_q)) begin
        if (leg1_q[i]) begin
          p_d = Pw'(int'(p_d) + 1);
        end else if (lm1_q && rex1_q[i]) begin
          p_d       = Pw'(int'(p_d) + 1);
          scan_done = 1'b1;
        end else begin
          scan_done = 1'b1;
        end
      end else begin
        scan_done = 1'b1;
      end
    end

    // Select opcode and the byte after it
    op_d  = '0;
    op2_d = '0;
    for (int i = 0; i < Keep; i++) begin
      if (int'(p_d) == i)     op_d  = bytes1_q[8*i +: 8];
      if (int'(p_d) + 1 == i) op2_d = bytes1_q[8*i +: 8];
    end
    op2_ok_d = (int'(p_d) + 1) < int'(n1_q);
  end

  logic [3:0]    n2_q;
  logic          lm2_q, call2_q, ret2_q, cond2_q, op2_ok2_q;
  logic [63:0]   tgt2_q;
  logic [Pw-1:0] p2_q;
  logic [7:0]    op2_q, op22_q;

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      n2_q      <= n1_q;
      lm2_q     <= lm1_q;
      call2_q   <= call1_q;
      ret2_q    <= ret1_q;
      cond2_q   <= cond1_q;
      tgt2_q    <= tgt_d;
      p2_q      <= p_d;
      op2_q     <= op_d;
      op22_q    <= op2_d;
      op2_ok2_q <= op2_ok_d;
    end
  end

  // ---------------- Stage 3: length table, output register ----------------
  logic [3:0] len_d;

  always_comb begin
    if (n2_q == 4'd0) begin
      len_d = 4'd0;
    end else if (int'(p2_q) >= int'(n2_q)) begin
      len_d = 4'd1;
    end else begin
      len_d = 4'(int'(p2_q) + int'(opcode_len(op2_q, op22_q, op2_ok2_q, lm2_q)));
    end
  end

  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_q.is_call        <= call2_q;
      out_q.is_return      <= ret2_q;
      out_q.is_cond_branch <= cond2_q;
      out_q.target_address <= tgt2_q;
      out_q.instr_length   <= len_d;
    end
  end

  assign out_o.valid = v3_q;
  assign out_o.data  = out_q;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the x86 branch and length predecoder.
module tb;
  import x86bpd_pkg::*;

  localparam int WinBytes    = 8;
  localparam int MaxPfx      = 4;
  localparam int RandomItems = 2000;
  localparam int MaxReports  = 40;
  localparam int DrainCycles = 10;

  // Legacy prefixes, REX and opcode groups as the decoder sees them
  localparam logic [7:0] LegacyPfx [11] = '{OpOpSize, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h2E,
                                            8'h36, 8'h3E, 8'h26, 8'h64, 8'h65};
  localparam logic [7:0] RetOps [4]    = '{OpRetNear, OpRetNearI, OpRetFar, OpRetFarI};
  localparam logic [7:0] OpMovzxB = 8'hB6;
  localparam logic [7:0] OpMovzxW = 8'hB7;
  localparam logic [7:0] OpMovsxB = 8'hBE;
  localparam logic [7:0] OpMovsxW = 8'hBF;
  localparam logic [7:0] WidenOps [4]  = '{OpMovzxB, OpMovzxW, OpMovsxB, OpMovsxW};
  localparam logic [7:0] OpLoopNz = 8'hE0;
  localparam logic [7:0] OpJcxz   = 8'hE3;
  localparam logic [7:0] OpMovImm = 8'hB8;
  localparam logic [7:0] OpRexW   = 8'h48;
  localparam logic [7:0] OpAddrSz = 8'h67;
  localparam logic [7:0] OpRep    = 8'hF3;
  localparam logic [3:0] RexNib      = 4'h4;
  localparam logic [3:0] PushPopNib  = 4'h5;
  localparam logic [3:0] JccShortNib = 4'h7;
  localparam logic [3:0] JccNearNib  = 4'h8;
  localparam logic [3:0] MovImmNib   = 4'hB;
  localparam logic [4:0] MovImmTop   = 5'b10111;
  localparam bit Typed     = 1'b1;
  localparam bit Predicted = 1'b0;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t known;
  } decode_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  x86bpd_in_if  in_ch ();
  x86bpd_out_if out_ch ();

  x86_branch_and_length_predecode dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  out_item_t   pending_decodes [$];
  decode_row_t directed_rows [$];
  out_item_t   oldest_decode;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  logic [7:0]  stall_pat = 8'hFF;

  always #5 clk_i = ~clk_i;

  function automatic bit is_prefix_byte(input logic [7:0] b);
    int i;
    for (i = 0; i < 11; i++) begin
      if (b == LegacyPfx[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected flags, direct target and length of one instruction window
  function automatic out_item_t predict_predecode(input in_item_t it);
    out_item_t   res;
    logic [7:0]  b [WinBytes];
    logic [63:0] a;
    int unsigned n, p, i;
    bit          scan;
    res = '0;
    a = it.instr_address;
    for (i = 0; i < WinBytes; i++) b[i] = it.instr_window[8*i +: 8];
    n = (it.valid_bytes > WinBytes) ? WinBytes : it.valid_bytes;

    // Flags look at byte 0, and at byte 1 after an FF or 0F opcode
    if (n >= 1) begin
      res.is_call = b[0] == OpCallRel || b[0] == OpCallFar ||
                    (b[0] == OpGrp5 && n >= 2 && b[1][5:3] == ModRmCall);
      res.is_return = b[0] == OpRetNear || b[0] == OpRetNearI ||
                      b[0] == OpRetFar || b[0] == OpRetFarI;
      res.is_cond_branch = b[0][7:4] == JccShortNib ||
                           (b[0] == OpEscape && n >= 2 && b[1][7:4] == JccNearNib) ||
                           (b[0] >= OpLoopNz && b[0] <= OpJcxz);
    end

    // Direct targets wrap at 64 bits
    if (n >= 2) begin
      if ((b[0] == OpCallRel || b[0] == OpJmpRel) && n >= 5) begin
        res.target_address = a + 64'd5 + {{32{b[4][7]}}, b[4], b[3], b[2], b[1]};
      end else if (b[0] == OpJmpShort || b[0][7:4] == JccShortNib) begin
        res.target_address = a + 64'd2 + {{56{b[1][7]}}, b[1]};
      end else if (b[0] == OpEscape && n >= 6 && b[1][7:4] == JccNearNib) begin
        res.target_address = a + 64'd6 + {{32{b[5][7]}}, b[5], b[4], b[3], b[2]};
      end
    end

    // Length: prefix scan, then the opcode table
    if (n >= 1) begin
      p = 0;
      scan = 1'b1;
      while (scan && p < n && p < MaxPfx) begin
        if (is_prefix_byte(b[p])) begin
          p++;
        end else if (it.long_mode && b[p][7:4] == RexNib) begin
          p++;
          scan = 1'b0;
        end else begin
          scan = 1'b0;
        end
      end
      if (p >= n) begin
        res.instr_length = 4'd1;
      end else if (b[p] == OpNop || b[p] == OpRetNear || b[p] == OpRetFar ||
                   b[p] == OpInt3 || b[p][7:4] == PushPopNib) begin
        res.instr_length = 4'(p + 1);
      end else if (b[p] == OpRetNearI || b[p] == OpRetFarI) begin
        res.instr_length = 4'(p + 3);
      end else if (b[p][7:3] == MovImmTop) begin
        res.instr_length = 4'(p + (it.long_mode ? 9 : 5));
      end else if (b[p] == OpCallRel || b[p] == OpJmpRel) begin
        res.instr_length = 4'(p + 5);
      end else if (b[p] == OpEscape && p + 1 < n && b[p+1][7:4] == JccNearNib) begin
        res.instr_length = 4'(p + 6);
      end else if (b[p] == OpEscape && p + 1 < n &&
                   (b[p+1] == OpMovzxB || b[p+1] == OpMovzxW ||
                    b[p+1] == OpMovsxB || b[p+1] == OpMovsxW)) begin
        res.instr_length = 4'(p + 3);
      end else begin
        res.instr_length = 4'(p + 2);
      end
    end
    return res;
  endfunction

  // Mostly well-formed instructions with random content, some pure noise
  function automatic in_item_t random_instr();
    in_item_t    it;
    logic [7:0]  b [WinBytes];
    int unsigned npfx, i;
    for (i = 0; i < WinBytes; i++) b[i] = 8'($urandom_range(0, 255));
    it.long_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: it.instr_address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 300));
      1: it.instr_address = 64'($urandom_range(0, 300));
      default: it.instr_address = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 6) == 0) begin
      it.instr_window = {$urandom, $urandom};
      it.valid_bytes = 4'($urandom_range(0, 8));
      return it;
    end
    npfx = $urandom_range(0, 1) ? 0 : $urandom_range(1, MaxPfx + 1);
    for (i = 0; i < npfx; i++) b[i] = LegacyPfx[$urandom_range(0, 10)];
    if ($urandom_range(0, 3) == 0) begin
      b[npfx] = {RexNib, 4'($urandom_range(0, 15))};
      npfx++;
    end
    case ($urandom_range(0, 14))
      0: b[npfx] = OpCallRel;
      1: b[npfx] = OpJmpRel;
      2: b[npfx] = OpJmpShort;
      3: b[npfx] = {JccShortNib, 4'($urandom_range(0, 15))};
      4: begin
        b[npfx] = OpEscape;
        b[npfx+1] = {JccNearNib, 4'($urandom_range(0, 15))};
      end
      5: begin
        b[npfx] = OpEscape;
        b[npfx+1] = WidenOps[$urandom_range(0, 3)];
      end
      6: b[npfx] = OpEscape;
      7: begin
        b[npfx] = OpGrp5;
        if ($urandom_range(0, 1)) b[npfx+1][5:3] = ModRmCall;
      end
      8: b[npfx] = OpCallFar;
      9: b[npfx] = RetOps[$urandom_range(0, 3)];
      10: b[npfx] = 8'($urandom_range(OpLoopNz, OpJcxz));
      11: b[npfx] = {MovImmNib, 4'($urandom_range(0, 15))};
      12: b[npfx] = {PushPopNib, 4'($urandom_range(0, 15))};
      13: b[npfx] = $urandom_range(0, 1) ? OpNop : OpInt3;
      default: ;
    endcase
    for (i = 0; i < WinBytes; i++) it.instr_window[8*i +: 8] = b[i];
    it.valid_bytes = ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(0, 8));
    return it;
  endfunction

  task automatic add_vec(input logic [63:0] addr, input logic [63:0] win,
                         input logic [3:0] n, input logic lm, input bit typed,
                         input int c, input int r, input int cb,
                         input logic [3:0] len);
    decode_row_t row;
    row.stim.instr_address = addr;
    row.stim.instr_window  = win;
    row.stim.valid_bytes   = n;
    row.stim.long_mode     = lm;
    row.typed = typed;
    row.known = {1'(c), 1'(r), 1'(cb), 64'h0, len};
    directed_rows.push_back(row);
  endtask

  // Offer one item in bursts with random gaps; hold until it is taken
  task automatic send_instr(input in_item_t it, input out_item_t want);
    int unsigned idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (idle != 0) begin
        in_ch.valid = 1'b0;
        repeat (idle) @(negedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_decodes.push_back(want);
    @(negedge clk_i);
  endtask

  // Receiver stall pattern: switch between randomly chosen modes
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(20, 200);
      stall_mode = $urandom_range(0, 3);
      stall_pat  = 8'($urandom_range(0, 255));
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = 1'($urandom_range(0, 1));
      2: out_ch.ready = ($urandom_range(0, 4) == 0);
      default: begin
        out_ch.ready = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: expected no result, got call=%b ret=%b cond=%b target=%h len=%0d",
                   $time, out_ch.data.is_call, out_ch.data.is_return,
                   out_ch.data.is_cond_branch, out_ch.data.target_address,
                   out_ch.data.instr_length);
        end
      end else begin
        oldest_decode = pending_decodes.pop_front();
        if (out_ch.data !== oldest_decode) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: expected call=%b ret=%b cond=%b target=%h len=%0d, %s",
                     $time, oldest_decode.is_call, oldest_decode.is_return,
                     oldest_decode.is_cond_branch, oldest_decode.target_address,
                     oldest_decode.instr_length,
                     $sformatf("got call=%b ret=%b cond=%b target=%h len=%0d",
                               out_ch.data.is_call, out_ch.data.is_return,
                               out_ch.data.is_cond_branch, out_ch.data.target_address,
                               out_ch.data.instr_length));
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_item_t  stim;
    out_item_t want;
    int        k;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: extremes, every branch class, short windows, prefixes
    add_vec('1, '1, 4'd0, 1'b1, Typed, 0, 0, 0, 4'd0);
    add_vec('0, '1, 4'd8, 1'b0, Typed, 0, 0, 0, 4'd2);
    add_vec('1, '0, 4'd8, 1'b1, Typed, 0, 0, 0, 4'd2);
    add_vec(64'h4000, 64'hC3, 4'd1, 1'b0, Typed, 0, 1, 0, 4'd1);
    add_vec(64'h4000, 64'h0008_00C2, 4'd3, 1'b0, Typed, 0, 1, 0, 4'd3);
    add_vec(64'h4000, 64'h1122_3344_5566_77CA, 4'd8, 1'b1, Typed, 0, 1, 0, 4'd3);
    add_vec(64'h7FFF_FFFF_0000_0000, 64'h0000_0080_0000_00E8, 4'd8, 1'b0,
            Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h2000, 64'h0056_3412_E8, 4'd4, 1'b0, Typed, 1, 0, 0, 4'd5);
    add_vec('1, 64'h0000_007F_FFFF_FFE9, 4'd8, 1'b1, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h10, 64'h80EB, 4'd8, 1'b0, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'hFFFF_FFFF_FFFF_FFC0, 64'h7F75, 4'd2, 1'b0, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h1234, 64'h0000_F030_2010_840F, 4'd6, 1'b0, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h1234, 64'h8F0F, 4'd5, 1'b0, Typed, 0, 0, 1, 4'd6);
    add_vec(64'h1234, 64'h000F, 4'd1, 1'b1, Typed, 0, 0, 0, 4'd2);
    add_vec(64'h1234, 64'hC0B60F, 4'd8, 1'b0, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h8000, 64'h10FF, 4'd2, 1'b0, Typed, 1, 0, 0, 4'd2);
    add_vec(64'h8000, 64'hD0FF, 4'd1, 1'b0, Typed, 0, 0, 0, 4'd2);
    add_vec(64'h8000, 64'h0008_1234_5678_009A, 4'd8, 1'b0, Typed, 1, 0, 0, 4'd2);
    add_vec(64'h8000, 64'h10E3, 4'd8, 1'b1, Typed, 0, 0, 1, 4'd2);
    add_vec(64'h9000, {24'h0, OpNop, {4{OpOpSize}}}, 4'd8, 1'b0, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h9000, {48'h0, OpRep, OpOpSize}, 4'd2, 1'b0, Typed, 0, 0, 0, 4'd1);
    add_vec(64'h9000, {48'h0, OpMovImm, OpRexW}, 4'd8, 1'b1, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h9000, {48'h0, OpMovImm, OpRexW}, 4'd8, 1'b0, Predicted, 0, 0, 0, 4'd0);
    add_vec(64'h9000, {24'h0, OpMovImm, OpRexW, OpRep, OpAddrSz, OpOpSize}, 4'd8, 1'b1,
            Predicted, 0, 0, 0, 4'd0);
    add_vec(64'hA000, {24'h0, 8'hFF, 8'hFF, 8'hFF, 8'hF0, OpCallRel}, 4'd15, 1'b0,
            Predicted, 0, 0, 0, 4'd0);

    for (k = 0; k < directed_rows.size(); k++) begin
      stim = directed_rows[k].stim;
      want = directed_rows[k].typed ? directed_rows[k].known : predict_predecode(stim);
      send_instr(stim, want);
    end

    // Random instructions, each checked against the predictor
    repeat (RandomItems) begin
      stim = random_instr();
      send_instr(stim, predict_predecode(stim));
    end
    in_ch.valid = 1'b0;

    // Drain the pipeline, then look for stray results
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
